// ===== hdl/window_gather_3x3_padded_macros.svh =====
// Assertion helpers shared by the window gather modules.
`ifndef WINDOW_GATHER_3X3_PADDED_MACROS_SVH
`define WINDOW_GATHER_3X3_PADDED_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WG3_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WG3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/wg3_pkg.sv =====
package wg3_pkg;

	// Frame geometry limits.
	localparam int MAX_WIDTH    = 64;
	localparam int MAX_HEIGHT   = 64;
	localparam int MAX_CHANNELS = 4;
	localparam int SAMPLE_BITS  = 16;
	localparam int WINDOW_SIZE  = 3;
	localparam int HALF         = WINDOW_SIZE / 2;

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int OFF_W       = $clog2(WINDOW_SIZE);

	// Register field widths.
	localparam int DIM_W     = 7;
	localparam int CHCFG_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam int PAD_COUNT = 4;
	localparam int PAD_IDX_W = 2;

	localparam int PIX_W  = ROW_W + DIM_W;
	localparam int SIZE_W = DIM_W + DIM_W + CHCFG_W;

	// Register reset values.
	localparam logic [DIM_W-1:0]   WIDTH_RESET    = DIM_W'(64);
	localparam logic [DIM_W-1:0]   HEIGHT_RESET   = DIM_W'(64);
	localparam logic [CHCFG_W-1:0] CHANNELS_RESET = CHCFG_W'(1);

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_CHANNELS = 3'd2,
		REG_PAD0     = 3'd3,
		REG_PAD1     = 3'd4,
		REG_PAD2     = 3'd5,
		REG_PAD3     = 3'd6
	} cfg_reg_t;

	// Input item kinds.
	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_REQUEST = 1'b1
	} kind_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_ADDR,
		ST_MEM,
		ST_PUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic calc_row;
		logic calc_addr;
		logic mem_read;
		logic push;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic in_kind;
		logic slot_free;
	} status_t;

endpackage

// ===== hdl/wg3_if.sv =====
// Input item channel.
interface wg3_item_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [wg3_pkg::SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, kind, sample_value, input ready);
	modport sink   (input valid, kind, sample_value, output ready);
endinterface

// Result item channel.
interface wg3_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [wg3_pkg::SAMPLE_BITS-1:0] window_value;
	logic                                is_pad;
	logic                                last_of_window;
	logic                                last_of_frame;
	logic                                not_ready;

	modport source (output valid, window_value, is_pad, last_of_window, last_of_frame,
		not_ready, input ready);
	modport sink   (input valid, window_value, is_pad, last_of_window, last_of_frame,
		not_ready, output ready);
endinterface

// ===== hdl/wg3_ctrl.sv =====
`include "window_gather_3x3_padded_macros.svh"

module wg3_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  wg3_pkg::status_t status,
	output logic             in_ready,
	output wg3_pkg::cmd_t    cmd
);

	wg3_pkg::state_t state_q;
	wg3_pkg::state_t state_d;
	logic            accept;

	// An item is taken only in idle and only when the result register can hold a new result.
	assign accept = status.in_valid && in_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wg3_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a load finishes in idle, a request walks the row, address, read and push steps.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wg3_pkg::ST_IDLE: begin
				if (accept && (status.in_kind == wg3_pkg::KIND_REQUEST)) begin
					state_d = wg3_pkg::ST_ROW;
				end
			end
			wg3_pkg::ST_ROW:  state_d = wg3_pkg::ST_ADDR;
			wg3_pkg::ST_ADDR: state_d = wg3_pkg::ST_MEM;
			wg3_pkg::ST_MEM:  state_d = wg3_pkg::ST_PUSH;
			wg3_pkg::ST_PUSH: state_d = wg3_pkg::ST_IDLE;
			default:          state_d = wg3_pkg::ST_IDLE;
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			wg3_pkg::ST_IDLE: begin
				in_ready   = status.slot_free;
				cmd.accept = status.in_valid && status.slot_free;
			end
			wg3_pkg::ST_ROW:  cmd.calc_row  = 1'b1;
			wg3_pkg::ST_ADDR: cmd.calc_addr = 1'b1;
			wg3_pkg::ST_MEM:  cmd.mem_read  = 1'b1;
			wg3_pkg::ST_PUSH: cmd.push      = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`WG3_ASSERT_NEXT(a_req_starts_lookup, clk, arst_n,
		accept && (status.in_kind == wg3_pkg::KIND_REQUEST), state_q == wg3_pkg::ST_ROW,
		"accepted request did not start a lookup")
	`WG3_ASSERT_NEXT(a_load_stays_idle, clk, arst_n,
		accept && (status.in_kind == wg3_pkg::KIND_LOAD), state_q == wg3_pkg::ST_IDLE,
		"accepted load left idle")
	`WG3_ASSERT_IMPL(a_ready_only_idle, clk, arst_n,
		in_ready, (state_q == wg3_pkg::ST_IDLE) && status.slot_free,
		"input ready while a lookup is in flight or the result slot is busy")

endmodule

// ===== hdl/wg3_datapath.sv =====
`include "window_gather_3x3_padded_macros.svh"

module wg3_datapath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  wg3_pkg::cmd_t                            cmd,
	output wg3_pkg::status_t                         status,
	input  logic                                     cfg_we,
	input  logic [wg3_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [wg3_pkg::CFG_W-1:0]                cfg_data,
	input  logic                                     in_valid,
	input  logic                                     in_kind,
	input  logic signed [wg3_pkg::SAMPLE_BITS-1:0]   in_sample,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [wg3_pkg::SAMPLE_BITS-1:0]   out_value,
	output logic                                     out_is_pad,
	output logic                                     out_last_window,
	output logic                                     out_last_frame,
	output logic                                     out_not_ready
);

	localparam int DW  = wg3_pkg::DIM_W;
	localparam int CW  = wg3_pkg::CHCFG_W;
	localparam int SB  = wg3_pkg::SAMPLE_BITS;
	localparam int SZW = wg3_pkg::SIZE_W;

	// Configuration registers.
	logic [DW-1:0]   width_q;
	logic [DW-1:0]   height_q;
	logic [CW-1:0]   channels_q;
	logic [SB-1:0]   pad_q [wg3_pkg::PAD_COUNT];

	// Frame and walk state.
	logic [wg3_pkg::COUNT_W-1:0] load_count_q;
	logic                        full_q;
	logic [wg3_pkg::ROW_W-1:0]   center_row_q;
	logic [wg3_pkg::COL_W-1:0]   center_col_q;
	logic [wg3_pkg::OFF_W-1:0]   off_row_q;
	logic [wg3_pkg::OFF_W-1:0]   off_col_q;
	logic [wg3_pkg::CH_W-1:0]    ch_idx_q;

	// Lookup pipeline.
	logic                         nr_s1;
	logic                         pad_s1;
	logic                         low_s1;
	logic                         lof_s1;
	logic [wg3_pkg::CH_W-1:0]     chn_s1;
	logic [wg3_pkg::ROW_W-1:0]    r_s1;
	logic [wg3_pkg::COL_W-1:0]    c_s1;
	logic [wg3_pkg::PIX_W-1:0]    pix_s2;
	logic [wg3_pkg::ADDR_W-1:0]   addr_s3;
	logic [SB-1:0]                rdata_s4;
	logic [SB-1:0]                store [wg3_pkg::STORE_DEPTH];

	// Result register.
	logic          out_valid_q;
	logic [SB-1:0] out_value_q;
	logic          out_pad_q;
	logic          out_low_q;
	logic          out_lof_q;
	logic          out_nr_q;

	// Effective geometry.
	logic [DW-1:0]                w_eff;
	logic [DW-1:0]                h_eff;
	logic [CW-1:0]                ch_eff;
	logic [2*DW-1:0]              wh;
	logic [SZW-1:0]               size;
	logic                         full_eff;
	logic                         load_last;

	// Window position of the current element.
	logic [DW-1:0]                row_sum;
	logic [DW-1:0]                col_sum;
	logic                         nbr_in_frame;
	logic [wg3_pkg::CH_W-1:0]     chn_eff;
	logic                         ch_last;
	logic                         oc_last;
	logic                         or_last;
	logic                         cc_last;
	logic                         cr_last;
	logic                         low;
	logic                         lof;
	logic [wg3_pkg::ADDR_W+1:0]   addr_sum;
	logic                         take_load;
	logic                         take_req;

	// Clamp the registers to the supported ranges.
	always_comb begin
		w_eff  = (width_q < DW'(2)) ? DW'(2) :
			((width_q > DW'(wg3_pkg::MAX_WIDTH)) ? DW'(wg3_pkg::MAX_WIDTH) : width_q);
		h_eff  = (height_q < DW'(1)) ? DW'(1) :
			((height_q > DW'(wg3_pkg::MAX_HEIGHT)) ? DW'(wg3_pkg::MAX_HEIGHT) : height_q);
		ch_eff = (channels_q < CW'(1)) ? CW'(1) :
			((channels_q > CW'(wg3_pkg::MAX_CHANNELS)) ? CW'(wg3_pkg::MAX_CHANNELS)
				: channels_q);
	end

	// Frame size: one small product, then the channel count by shift and add.
	assign wh   = w_eff * h_eff;
	assign size = (ch_eff[0] ? SZW'(wh) : '0) + (ch_eff[1] ? (SZW'(wh) << 1) : '0)
		+ (ch_eff[2] ? (SZW'(wh) << 2) : '0);

	assign full_eff  = full_q || (SZW'(load_count_q) >= size);
	assign load_last = (SZW'(load_count_q) + SZW'(1)) >= size;

	// Neighbour position and the frame-boundary test.
	always_comb begin
		row_sum = DW'(center_row_q) + DW'(off_row_q);
		col_sum = DW'(center_col_q) + DW'(off_col_q);
		nbr_in_frame = (row_sum >= DW'(wg3_pkg::HALF))
			&& ((row_sum - DW'(wg3_pkg::HALF)) < h_eff)
			&& (col_sum >= DW'(wg3_pkg::HALF)) && ((col_sum - DW'(wg3_pkg::HALF)) < w_eff);
		chn_eff = (CW'(ch_idx_q) >= ch_eff) ? wg3_pkg::CH_W'(ch_eff - CW'(1)) : ch_idx_q;
	end

	// Wrap conditions of the walk counters.
	always_comb begin
		ch_last = (CW'(ch_idx_q) + CW'(1)) >= ch_eff;
		oc_last = (CW'(off_col_q) + CW'(1)) >= CW'(wg3_pkg::WINDOW_SIZE);
		or_last = (CW'(off_row_q) + CW'(1)) >= CW'(wg3_pkg::WINDOW_SIZE);
		cc_last = (DW'(center_col_q) + DW'(1)) >= w_eff;
		cr_last = (DW'(center_row_q) + DW'(1)) >= h_eff;
		low     = ch_last && oc_last && or_last;
		lof     = low && cc_last && cr_last;
	end

	assign take_load = cmd.accept && in_valid && (in_kind == wg3_pkg::KIND_LOAD);
	assign take_req  = cmd.accept && in_valid && (in_kind == wg3_pkg::KIND_REQUEST);

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= wg3_pkg::WIDTH_RESET;
			height_q   <= wg3_pkg::HEIGHT_RESET;
			channels_q <= wg3_pkg::CHANNELS_RESET;
			for (int i = 0; i < wg3_pkg::PAD_COUNT; i++) begin
				pad_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				wg3_pkg::REG_WIDTH:    width_q    <= cfg_data[DW-1:0];
				wg3_pkg::REG_HEIGHT:   height_q   <= cfg_data[DW-1:0];
				wg3_pkg::REG_CHANNELS: channels_q <= cfg_data[CW-1:0];
				wg3_pkg::REG_PAD0, wg3_pkg::REG_PAD1, wg3_pkg::REG_PAD2,
				wg3_pkg::REG_PAD3: begin
					pad_q[wg3_pkg::PAD_IDX_W'(cfg_index - wg3_pkg::REG_PAD0)] <= cfg_data[SB-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Load counter, full flag and the window walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			full_q       <= 1'b0;
			center_row_q <= '0;
			center_col_q <= '0;
			off_row_q    <= '0;
			off_col_q    <= '0;
			ch_idx_q     <= '0;
		end else if (take_load) begin
			if (full_eff) begin
				full_q <= 1'b1;
			end else begin
				load_count_q <= load_count_q + wg3_pkg::COUNT_W'(1);
				full_q       <= load_last;
			end
		end else if (take_req) begin
			full_q <= full_eff;
			if (full_eff) begin
				ch_idx_q <= ch_last ? '0 : ch_idx_q + wg3_pkg::CH_W'(1);
				if (ch_last) begin
					off_col_q <= oc_last ? '0 : off_col_q + wg3_pkg::OFF_W'(1);
					if (oc_last) begin
						off_row_q <= or_last ? '0 : off_row_q + wg3_pkg::OFF_W'(1);
						if (or_last) begin
							center_col_q <= cc_last ? '0 : center_col_q + wg3_pkg::COL_W'(1);
							if (cc_last) begin
								center_row_q <= cr_last ? '0
									: center_row_q + wg3_pkg::ROW_W'(1);
								if (cr_last) begin
									load_count_q <= '0;
									full_q       <= 1'b0;
								end
							end
						end
					end
				end
			end
		end
	end

	// Snapshot of the requested element.
	always_ff @(posedge clk) begin
		if (take_req) begin
			nr_s1  <= !full_eff;
			pad_s1 <= !nbr_in_frame;
			low_s1 <= low;
			lof_s1 <= lof;
			chn_s1 <= chn_eff;
			r_s1   <= wg3_pkg::ROW_W'(row_sum - DW'(wg3_pkg::HALF));
			c_s1   <= wg3_pkg::COL_W'(col_sum - DW'(wg3_pkg::HALF));
		end
	end

	// Pixel index from row and column.
	always_ff @(posedge clk) begin
		if (cmd.calc_row) begin
			pix_s2 <= wg3_pkg::PIX_W'(r_s1) * wg3_pkg::PIX_W'(w_eff) + wg3_pkg::PIX_W'(c_s1);
		end
	end

	// Sample address: pixel index times the channel count, plus the channel.
	assign addr_sum = (ch_eff[0] ? (wg3_pkg::ADDR_W+2)'(pix_s2) : '0)
		+ (ch_eff[1] ? ((wg3_pkg::ADDR_W+2)'(pix_s2) << 1) : '0)
		+ (ch_eff[2] ? ((wg3_pkg::ADDR_W+2)'(pix_s2) << 2) : '0)
		+ (wg3_pkg::ADDR_W+2)'(chn_s1);

	always_ff @(posedge clk) begin
		if (cmd.calc_addr) begin
			addr_s3 <= addr_sum[wg3_pkg::ADDR_W-1:0];
		end
	end

	// Frame store: one write port for loads, one registered read for lookups.
	always_ff @(posedge clk) begin
		if (take_load && !full_eff && !load_count_q[wg3_pkg::ADDR_W]) begin
			store[load_count_q[wg3_pkg::ADDR_W-1:0]] <= in_sample;
		end
		if (cmd.mem_read) begin
			rdata_s4 <= store[addr_s3];
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload; a not-ready result carries zeros.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_nr_q    <= nr_s1;
			out_pad_q   <= !nr_s1 && pad_s1;
			out_low_q   <= !nr_s1 && low_s1;
			out_lof_q   <= !nr_s1 && lof_s1;
			out_value_q <= nr_s1 ? '0 : (pad_s1 ? pad_q[chn_s1] : rdata_s4);
		end
	end

	assign status.in_valid  = in_valid;
	assign status.in_kind   = in_kind;
	assign status.slot_free = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign out_is_pad      = out_pad_q;
	assign out_last_window = out_low_q;
	assign out_last_frame  = out_lof_q;
	assign out_not_ready   = out_nr_q;

	`WG3_ASSERT_IMPL(a_push_into_free_slot, clk, arst_n,
		cmd.push, !out_valid_q || out_ready,
		"result pushed over a result not yet transferred")
	`WG3_ASSERT_IMPL(a_load_count_bound, clk, arst_n,
		1'b1, load_count_q <= wg3_pkg::COUNT_W'(wg3_pkg::STORE_DEPTH),
		"load counter ran past the store depth")
	`WG3_ASSERT_IMPL(a_frame_mark_in_window, clk, arst_n,
		out_valid_q && out_lof_q, out_low_q && !out_nr_q,
		"last-of-frame without last-of-window")

endmodule

// ===== hdl/window_gather_3x3_padded.sv =====
// 3x3 window gather with same padding. Load a frame as input items of kind load, in raster
// order with the channel changing fastest; a load gives no result, and loads into a full
// frame are dropped. Then send one request item per output element: centers go in raster
// order, within a center the nine neighbours row by row, within a neighbour the channels;
// outside the frame the channel's pad value is returned with is_pad set. A request before
// the frame is complete returns not_ready and moves nothing. Each request passes through
// capture, row product, address, frame store read and result register in that order; the
// next item is taken once these steps are done and the result register is free or being
// transferred. After the last element of the frame has been read the block takes the next
// frame. Write configuration only while idle.
module window_gather_3x3_padded (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wg3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wg3_pkg::CFG_W-1:0]         cfg_data,
	wg3_item_if.sink                          in_ch,
	wg3_result_if.source                      out_ch
);

	wg3_pkg::cmd_t    cmd;
	wg3_pkg::status_t status;
	logic             in_ready;

	// Sequencer for loads and lookups.
	wg3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Registers, counters, frame store and result register.
	wg3_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_ch.valid),
		.in_kind         (in_ch.kind),
		.in_sample       (in_ch.sample_value),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.out_value       (out_ch.window_value),
		.out_is_pad      (out_ch.is_pad),
		.out_last_window (out_ch.last_of_window),
		.out_last_frame  (out_ch.last_of_frame),
		.out_not_ready   (out_ch.not_ready)
	);

	assign in_ch.ready = in_ready;

endmodule
